/* rtl/tme_pkg.sv */
// Shared opcode, status and bus layout constants for the tape machine execute unit.
`timescale 1ns / 1ps

package tme_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_MOVE  = 4'd1;
  localparam logic [3:0] OP_OUT   = 4'd2;
  localparam logic [3:0] OP_IN    = 4'd3;
  localparam logic [3:0] OP_ZERO  = 4'd4;
  localparam logic [3:0] OP_SET   = 4'd5;
  localparam logic [3:0] OP_SETAT = 4'd6;
  localparam logic [3:0] OP_MADD  = 4'd7;
  localparam logic [3:0] OP_SKIP  = 4'd8;
  localparam logic [3:0] OP_TEST  = 4'd9;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SKIP  = 2'd2;

endpackage

/* rtl/tape_machine_execute_unit.sv */
// Tape machine execute unit: byte tape in one single-port RAM, head pointer, op sequencer.
`timescale 1ns / 1ps

// After reset the unit sweeps the tape RAM to zero, one cell per clock, so in_tready stays
// low until the sweep is done. Then each instruction beat is accepted as the RAM read of
// the current cell is issued, and the execute state does the update; move and multiply-add
// pass a further state for a second access to the single-port tape RAM; skip-scan reads one
// cell per scan step. Exactly one result beat leaves per instruction beat; a pending result
// that is not taken holds the sequencer, but the next instruction can be accepted.
module tape_machine_execute_unit
  import tme_pkg::*;
#(
  parameter int TAPE_DEPTH = 32768,
  parameter int CELL_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // amount[15:0], offset[31:16], in_byte[39:32]
  input  logic [3:0]            in_tuser,   // operation[3:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_byte[7:0], cell_nonzero[8], status[10:9],
                                            // head_position[25:11], zero[31:26]
  output logic                  out_tuser   // out_valid[0]
);

  localparam int AW  = $clog2(TAPE_DEPTH);
  localparam int PW  = ((AW > 16) ? AW : 16) + 2;
  localparam int HW  = (AW > 15) ? AW : 15;
  localparam logic [PW-1:0] LIM  = PW'(TAPE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(TAPE_DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_MADD  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;

  function automatic logic in_tape(input logic signed [PW-1:0] p);
    return (!p[PW-1]) && ($unsigned(p) < LIM);
  endfunction

  logic [CELL_BITS-1:0] tape_mem [TAPE_DEPTH];
  logic [CELL_BITS-1:0] rdata_r;
  logic                 mem_en, mem_we;
  logic [AW-1:0]        mem_addr;
  logic [CELL_BITS-1:0] mem_wdata;

  logic [2:0]           state_r, state_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        tgt_r, tgt_nxt;
  logic [3:0]           op_r, op_nxt;
  logic [15:0]          amt_r, amt_nxt;
  logic [15:0]          off_r, off_nxt;
  logic [7:0]           inb_r, inb_nxt;
  logic [CELL_BITS-1:0] prod_r, prod_nxt;
  logic                 cnz_r, cnz_nxt;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic                  out_tuser_r, out_tuser_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                   out_free;
  logic                   fin;
  logic                   f_user, f_nz;
  logic [7:0]             f_byte;
  logic [1:0]             f_st;
  logic [HW-1:0]          head_ext;
  logic signed [PW-1:0]   head_s, pos_s, amt_s, off_s, mv_pos, tgt_pos, sc_pos;
  logic [CELL_BITS-1:0]   cur, amt_cell, wval;
  logic [2*CELL_BITS-1:0] prod_full;

  assign cur       = rdata_r;
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  assign head_s   = $signed({{(PW-AW){1'b0}}, head_r});
  assign pos_s    = $signed({{(PW-AW){1'b0}}, pos_r});
  assign amt_s    = PW'($signed(amt_r));
  assign off_s    = PW'($signed(off_r));
  assign mv_pos   = head_s + amt_s;
  assign tgt_pos  = head_s + off_s;
  assign sc_pos   = pos_s + amt_s;
  assign amt_cell = CELL_BITS'($signed(amt_r));
  assign prod_full = cur * amt_cell;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    clr_nxt        = clr_r;
    pos_nxt        = pos_r;
    tgt_nxt        = tgt_r;
    op_nxt         = op_r;
    amt_nxt        = amt_r;
    off_nxt        = off_r;
    inb_nxt        = inb_r;
    prod_nxt       = prod_r;
    cnz_nxt        = cnz_r;
    mem_en         = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = head_r;
    mem_wdata      = '0;
    wval           = '0;
    fin            = 1'b0;
    f_user         = 1'b0;
    f_byte         = '0;
    f_nz           = (cur != '0);
    f_st           = ST_OK;
    case (state_r)
      S_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          amt_nxt   = in_tdata[15:0];
          off_nxt   = in_tdata[31:16];
          inb_nxt   = in_tdata[39:32];
          mem_en    = 1'b1;
          mem_addr  = head_r;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          case (op_r)
            OP_ADD, OP_IN, OP_ZERO, OP_SET: begin
              case (op_r)
                OP_ADD:  wval = cur + amt_cell;
                OP_IN:   wval = CELL_BITS'(inb_r);
                OP_SET:  wval = amt_cell;
                default: wval = '0;
              endcase
              mem_en    = 1'b1;
              mem_we    = 1'b1;
              mem_wdata = wval;
              f_nz      = (wval != '0);
              fin       = 1'b1;
            end
            OP_MOVE: begin
              if (in_tape(mv_pos)) begin
                head_nxt  = mv_pos[AW-1:0];
                mem_en    = 1'b1;
                mem_addr  = mv_pos[AW-1:0];
                state_nxt = S_LOOK;
              end else begin
                f_st = ST_RANGE;
                fin  = 1'b1;
              end
            end
            OP_OUT: begin
              f_user = 1'b1;
              f_byte = cur[7:0];
              fin    = 1'b1;
            end
            OP_SETAT: begin
              if (in_tape(tgt_pos)) begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = tgt_pos[AW-1:0];
                mem_wdata = amt_cell;
                if (tgt_pos[AW-1:0] == head_r) begin
                  f_nz = (amt_cell != '0);
                end
              end else begin
                f_st = ST_RANGE;
              end
              fin = 1'b1;
            end
            OP_MADD: begin
              if (in_tape(tgt_pos)) begin
                prod_nxt  = prod_full[CELL_BITS-1:0];
                cnz_nxt   = (cur != '0);
                tgt_nxt   = tgt_pos[AW-1:0];
                mem_en    = 1'b1;
                mem_addr  = tgt_pos[AW-1:0];
                state_nxt = S_MADD;
              end else begin
                f_st = ST_RANGE;
                fin  = 1'b1;
              end
            end
            OP_SKIP: begin
              if (cur == '0) begin
                fin = 1'b1;
              end else if (amt_r == '0 || !in_tape(mv_pos)) begin
                f_st = ST_SKIP;
                fin  = 1'b1;
              end else begin
                pos_nxt   = mv_pos[AW-1:0];
                mem_en    = 1'b1;
                mem_addr  = mv_pos[AW-1:0];
                state_nxt = S_SCAN;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (out_free) begin
          fin = 1'b1;
        end
      end
      S_MADD: begin
        if (out_free) begin
          wval      = cur + prod_r;
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = tgt_r;
          mem_wdata = wval;
          f_nz      = (tgt_r == head_r) ? (wval != '0) : cnz_r;
          fin       = 1'b1;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (cur == '0) begin
            head_nxt = pos_r;
            fin      = 1'b1;
          end else if (!in_tape(sc_pos)) begin
            head_nxt = pos_r;
            f_st     = ST_SKIP;
            fin      = 1'b1;
          end else begin
            pos_nxt  = sc_pos[AW-1:0];
            mem_en   = 1'b1;
            mem_addr = sc_pos[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  assign head_ext = HW'(head_nxt);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tuser_nxt  = out_tuser_r;
    out_tdata_nxt  = out_tdata_r;
    if (fin) begin
      out_tvalid_nxt = 1'b1;
      out_tuser_nxt  = f_user;
      out_tdata_nxt  = {6'd0, head_ext[14:0], f_st, f_nz, f_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) begin
        tape_mem[mem_addr] <= mem_wdata;
      end else begin
        rdata_r <= tape_mem[mem_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      head_r       <= '0;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    tgt_r       <= tgt_nxt;
    op_r        <= op_nxt;
    amt_r       <= amt_nxt;
    off_r       <= off_nxt;
    inb_r       <= inb_nxt;
    prod_r      <= prod_nxt;
    cnz_r       <= cnz_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* rtl/tme_checker.sv */
// Port-level checks for the tape machine execute unit, bound to the top level.
`timescale 1ns / 1ps

module tme_checker
  import tme_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [3:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:9] == ST_OK || out_tdata[10:9] == ST_RANGE ||
                    out_tdata[10:9] == ST_SKIP))
    else $error("bad status code");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[10:9] == ST_OK)
    else $error("output byte beat with error status");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0 && out_tdata[31:26] == 6'd0)
    else $error("stray byte or padding bits");

endmodule

bind tape_machine_execute_unit tme_checker u_tme_checker (.*);

/* verif/testbench.sv */
// Testbench for the tape machine execute unit: directed and random instructions against a tape mirror.
`timescale 1ns / 1ps

module testbench;
  import tme_pkg::*;

  localparam int DEPTH          = 32768;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int PHASE_ITEMS    = 156;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  byte_val;
    logic        nonzero;
    logic [1:0]  status;
    logic [14:0] head;
  } step_result_t;

  class tape_mirror;
    bit [7:0]     cells [DEPTH];
    bit [14:0]    head;
    step_result_t pending_results[$];
    int           mismatches;
    int           checked;
    int           range_errs;
    int           skip_aborts;
    int           bytes_out;

    function bit on_tape(int pos);
      return pos >= 0 && pos < DEPTH;
    endfunction

    function void apply_instr(logic [3:0] op, logic [IN_DATA_W-1:0] data);
      logic signed [15:0] amt;
      logic signed [15:0] off;
      logic [7:0]         ib;
      logic [7:0]         cur;
      int                 tgt;
      int                 np;
      int                 pos;
      bit                 done;
      step_result_t       r;
      amt = data[15:0];
      off = data[31:16];
      ib  = data[39:32];
      cur = cells[head];
      tgt = int'(head) + int'(off);
      r   = '0;
      r.status = ST_OK;
      case (op)
        OP_ADD:   cells[head] = cur + amt[7:0];
        OP_MOVE: begin
          np = int'(head) + int'(amt);
          if (on_tape(np)) head = np[14:0];
          else r.status = ST_RANGE;
        end
        OP_OUT: begin
          r.byte_valid = 1'b1;
          r.byte_val   = cur;
        end
        OP_IN:    cells[head] = ib;
        OP_ZERO:  cells[head] = 8'd0;
        OP_SET:   cells[head] = amt[7:0];
        OP_SETAT: begin
          if (on_tape(tgt)) cells[tgt] = amt[7:0];
          else r.status = ST_RANGE;
        end
        OP_MADD: begin
          if (on_tape(tgt)) cells[tgt] = cells[tgt] + cur * amt[7:0];
          else r.status = ST_RANGE;
        end
        OP_SKIP: begin
          if (cur != 8'd0) begin
            if (amt == 16'sd0) begin
              r.status = ST_SKIP;
            end else begin
              pos  = int'(head);
              done = 1'b0;
              while (!done) begin
                np = pos + int'(amt);
                if (!on_tape(np)) begin
                  r.status = ST_SKIP;
                  done = 1'b1;
                end else begin
                  pos = np;
                  if (cells[pos] == 8'd0) done = 1'b1;
                end
              end
              head = pos[14:0];
            end
          end
        end
        default: ;
      endcase
      r.nonzero = cells[head] != 8'd0;
      r.head    = head;
      if (r.status == ST_RANGE) range_errs++;
      if (r.status == ST_SKIP) skip_aborts++;
      if (r.byte_valid) bytes_out++;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d, logic u);
      step_result_t e;
      step_result_t a;
      a.byte_valid = u;
      a.byte_val   = d[7:0];
      a.nonzero    = d[8];
      a.status     = d[10:9];
      a.head       = d[25:11];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: tdata %h tuser %b", d, u);
        return;
      end
      e = pending_results.pop_front();
      checked++;
      if (a.byte_valid !== e.byte_valid || a.byte_val !== e.byte_val ||
          a.nonzero !== e.nonzero || a.status !== e.status || a.head !== e.head ||
          d[31:26] !== 6'd0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("result %0d: exp valid %b byte %h nz %b st %0d head %0d",
                 checked, e.byte_valid, e.byte_val, e.nonzero, e.status, e.head);
          $display(" | got valid %b byte %h nz %b st %0d head %0d pad %h",
                   a.byte_valid, a.byte_val, a.nonzero, a.status, a.head, d[31:26]);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [3:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  tape_machine_execute_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  tape_mirror mirror = new();
  int idle_pct     = 0;
  int stall_pct    = 0;
  int stuck_cycles = 0;
  int instrs_sent  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_pct > 0 && $urandom_range(99) < stall_pct) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) mirror.apply_instr(in_tuser, in_tdata);
      if (out_tvalid && out_tready) mirror.check_result(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic send_instr(input logic [3:0] op, input logic [15:0] amt,
                            input logic [15:0] off, input logic [7:0] ib);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {ib, off, amt};
    do @(posedge clk); while (!in_tready);
    instrs_sent++;
  endtask

  function automatic logic [15:0] rand_field();
    int sel;
    int v;
    logic [15:0] f;
    sel = $urandom_range(99);
    if (sel < 70) begin
      v = int'($urandom_range(12)) - 6;
      f = v[15:0];
    end else if (sel < 85) begin
      f = 16'($urandom);
    end else begin
      case ($urandom_range(4))
        0:       f = 16'h7FFF;
        1:       f = 16'h8000;
        2:       f = 16'hFFFF;
        3:       f = 16'h0001;
        default: f = 16'h0000;
      endcase
    end
    return f;
  endfunction

  task automatic send_random();
    int          pick;
    int          a;
    logic [3:0]  op;
    logic [15:0] amt;
    logic [15:0] off;
    pick = $urandom_range(99);
    if (pick < 14)      op = OP_ADD;
    else if (pick < 28) op = OP_MOVE;
    else if (pick < 36) op = OP_OUT;
    else if (pick < 44) op = OP_IN;
    else if (pick < 48) op = OP_ZERO;
    else if (pick < 56) op = OP_SET;
    else if (pick < 66) op = OP_SETAT;
    else if (pick < 78) op = OP_MADD;
    else if (pick < 90) op = OP_SKIP;
    else if (pick < 94) op = OP_TEST;
    else                op = 4'($urandom_range(15, 10));
    amt = rand_field();
    off = rand_field();
    // occasional jump between the two ends of the tape
    if (op == OP_MOVE && $urandom_range(99) < 8) begin
      if (mirror.head < 15'd16384) a = int'($urandom_range(32767, 32755)) - int'(mirror.head);
      else a = int'($urandom_range(12)) - int'(mirror.head);
      amt = a[15:0];
    end
    send_instr(op, amt, off, 8'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_instr(OP_OUT,   16'd0,     16'd0,     8'd0);
    send_instr(OP_SKIP,  16'd5,     16'd0,     8'd0);
    send_instr(OP_MOVE,  16'hFFFF,  16'd0,     8'd0);
    send_instr(OP_ADD,   16'h7FFF,  16'd0,     8'd0);
    send_instr(OP_ADD,   16'h8000,  16'd0,     8'd0);
    send_instr(OP_OUT,   16'd0,     16'd0,     8'd0);
    send_instr(OP_SKIP,  16'd0,     16'd0,     8'd0);
    send_instr(OP_SKIP,  16'hFFFF,  16'd0,     8'd0);
    send_instr(OP_IN,    16'd0,     16'd0,     8'hA5);
    send_instr(OP_SETAT, 16'd9,     16'hFFFF,  8'd0);
    send_instr(OP_SETAT, 16'd7,     16'h7FFF,  8'd0);
    send_instr(OP_SETAT, 16'd3,     16'h7FFE,  8'd0);
    send_instr(OP_MADD,  16'hFFFF,  16'd1,     8'd0);
    send_instr(OP_MADD,  16'd2,     16'h8000,  8'd0);
    send_instr(OP_MOVE,  16'h7FFE,  16'd0,     8'd0);
    send_instr(OP_SKIP,  16'd1,     16'd0,     8'd0);
    send_instr(OP_MOVE,  16'd1,     16'd0,     8'd0);
    send_instr(OP_SKIP,  16'd1,     16'd0,     8'd0);
    send_instr(OP_MOVE,  16'hFFFD,  16'd0,     8'd0);
    send_instr(OP_SET,   16'h8001,  16'd0,     8'd0);
    send_instr(OP_ZERO,  16'd0,     16'd0,     8'd0);
    send_instr(OP_TEST,  16'd0,     16'd0,     8'd0);
    for (int op = 10; op < 16; op++) send_instr(4'(op), 16'h1234, 16'h5678, 8'h5A);
    send_instr(OP_MOVE,  16'h8000,  16'd0,     8'd0);
    send_instr(OP_MOVE,  16'h8004,  16'd0,     8'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
      // hold off until the unit has drained
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (mirror.pending_results.size() != 0) @(posedge clk);
    end

    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d instructions over four idle/stall mixes, %0d result beats checked",
             instrs_sent, mirror.checked);
    $display("%0d range errors, %0d skip-scan aborts, %0d output bytes, %0d mismatches",
             mirror.range_errs, mirror.skip_aborts, mirror.bytes_out, mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* tape_machine_execute_unit.f */
rtl/tme_pkg.sv
rtl/tape_machine_execute_unit.sv
rtl/tme_checker.sv
verif/testbench.sv
